/* design/tcl_pkg.sv */
// Shared types, token codes and keyword tables for the token classifier.
package tcl_pkg;

	// Token kinds as seen on the result channel
	localparam logic [2:0] TK_KEYWORD = 3'd0;
	localparam logic [2:0] TK_IDENT   = 3'd1;
	localparam logic [2:0] TK_NUMBER  = 3'd2;
	localparam logic [2:0] TK_PUNCT   = 3'd3;
	localparam logic [2:0] TK_ARITH   = 3'd4;
	localparam logic [2:0] TK_ASSIGN  = 3'd5;
	localparam logic [2:0] TK_LOGIC   = 3'd6;
	// Internal marker: byte is not a single-character token
	localparam logic [2:0] TK_NONE    = 3'd7;

	// Kind of the word in progress
	localparam logic [1:0] WK_NONE = 2'd0;
	localparam logic [1:0] WK_NAME = 2'd1;
	localparam logic [1:0] WK_NUM  = 2'd2;

	localparam int KW_COUNT = 4;
	localparam int KW_SPAN  = 6;

	// Result queue depth and count width
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] length;
		logic [7:0] chr;
		logic       sat;
		logic       last;
	} result_t;

	// Up to two results produced by one accepted item, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} emit_t;

	// Keyword text: int, main, return, for; zero past the end
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
		logic [7:0] ch;
		ch = 8'd0;
		case (k)
			2'd0: begin
				case (p)
					3'd0: ch = "i";
					3'd1: ch = "n";
					3'd2: ch = "t";
					default: ch = 8'd0;
				endcase
			end
			2'd1: begin
				case (p)
					3'd0: ch = "m";
					3'd1: ch = "a";
					3'd2: ch = "i";
					3'd3: ch = "n";
					default: ch = 8'd0;
				endcase
			end
			2'd2: begin
				case (p)
					3'd0: ch = "r";
					3'd1: ch = "e";
					3'd2: ch = "t";
					3'd3: ch = "u";
					3'd4: ch = "r";
					3'd5: ch = "n";
					default: ch = 8'd0;
				endcase
			end
			default: begin
				case (p)
					3'd0: ch = "f";
					3'd1: ch = "o";
					3'd2: ch = "r";
					default: ch = 8'd0;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] n;
		case (k)
			2'd0: n = 3'd3;
			2'd1: n = 3'd4;
			2'd2: n = 3'd6;
			default: n = 3'd3;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] single_kind(input logic [7:0] c);
		logic [2:0] sk;
		case (c)
			";", ".", ":": sk = TK_PUNCT;
			"+", "-", "*", "/": sk = TK_ARITH;
			"=", "(", ")", "{", "}": sk = TK_ASSIGN;
			"<", ">": sk = TK_LOGIC;
			default: sk = TK_NONE;
		endcase
		return sk;
	endfunction

endpackage

/* design/tcl_if.sv */
// Valid/ready channel interfaces for characters in and tokens out.
interface tcl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_end;

	modport source (output valid, output char_in, output line_end, input ready);
	modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface tcl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] token_length;
	logic [7:0] token_char;
	logic       length_saturated;
	logic       last_of_run;

	modport source (output valid, output token_kind, output token_length,
		output token_char, output length_saturated, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_length,
		input token_char, input length_saturated, input last_of_run, output ready);
endinterface

/* design/tcl_word.sv */
// Word state registers and per-character classification logic.
module tcl_word #(
	parameter int MAX_WORD_LEN = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_in,
	input  logic           line_end,
	output tcl_pkg::emit_t emit
);

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

	typedef struct packed {
		logic [1:0]       kind;
		logic [LEN_W-1:0] len;
		logic [3:0]       mask;
		logic             ovf;
	} word_t;

	localparam word_t WORD_CLEAR = '{kind: tcl_pkg::WK_NONE, len: '0, mask: 4'hF, ovf: 1'b0};

	word_t word_q;
	word_t word_nxt;

	function automatic word_t add_char(input word_t w, input logic [7:0] c);
		word_t r;
		r = w;
		for (int k = 0; k < tcl_pkg::KW_COUNT; k++) begin
			if (w.len >= LEN_W'(tcl_pkg::KW_SPAN) ||
			    tcl_pkg::kw_char(2'(k), w.len[2:0]) != c) begin
				r.mask[k] = 1'b0;
			end
		end
		if (w.len < LEN_W'(MAX_WORD_LEN)) begin
			r.len = w.len + LEN_W'(1);
		end else begin
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	function automatic tcl_pkg::result_t emit_word(input word_t w);
		tcl_pkg::result_t r;
		r.kind   = tcl_pkg::TK_NUMBER;
		r.length = 8'(w.len);
		r.chr    = 8'd0;
		r.sat    = w.ovf;
		r.last   = 1'b0;
		if (w.kind == tcl_pkg::WK_NAME) begin
			r.kind = tcl_pkg::TK_IDENT;
			if (!w.ovf) begin
				for (int k = 0; k < tcl_pkg::KW_COUNT; k++) begin
					if (w.mask[k] && LEN_W'(tcl_pkg::kw_len(2'(k))) == w.len) begin
						r.kind = tcl_pkg::TK_KEYWORD;
					end
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		logic             is_l;
		logic             is_d;
		logic             is_u;
		logic             ext;
		logic             v1;
		logic             v2;
		logic             v3;
		logic [2:0]       sk;
		tcl_pkg::result_t e1;
		tcl_pkg::result_t e2;
		tcl_pkg::result_t e3;
		tcl_pkg::result_t r0;
		tcl_pkg::result_t r1;
		logic [1:0]       n;

		is_l = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
		is_d = char_in >= "0" && char_in <= "9";
		is_u = char_in == "_";
		sk   = tcl_pkg::single_kind(char_in);
		ext  = (word_q.kind == tcl_pkg::WK_NAME && (is_l || is_d || is_u)) ||
		       (word_q.kind == tcl_pkg::WK_NUM && is_d);
		v1 = 1'b0;
		v2 = 1'b0;
		v3 = 1'b0;
		e1 = emit_word(word_q);
		e2 = '{kind: sk, length: 8'd1, chr: char_in, sat: 1'b0, last: 1'b0};
		word_nxt = word_q;

		if (ext) begin
			word_nxt = add_char(word_q, char_in);
		end else begin
			v1 = word_q.kind != tcl_pkg::WK_NONE;
			word_nxt = WORD_CLEAR;
			if (is_l || is_u) begin
				word_nxt.kind = tcl_pkg::WK_NAME;
				word_nxt = add_char(word_nxt, char_in);
			end else if (is_d) begin
				word_nxt.kind = tcl_pkg::WK_NUM;
				word_nxt = add_char(word_nxt, char_in);
			end else begin
				v2 = sk != tcl_pkg::TK_NONE;
			end
		end

		// Line end flushes whatever word is left after this byte
		e3 = emit_word(word_nxt);
		if (line_end && word_nxt.kind != tcl_pkg::WK_NONE && !(v1 && v2)) begin
			v3 = 1'b1;
			word_nxt = WORD_CLEAR;
		end

		// Pack in order; the single token and the flush never both occur
		r0 = v1 ? e1 : (v2 ? e2 : e3);
		r1 = v2 ? e2 : e3;
		n  = 2'(v1) + 2'(v2) + 2'(v3);
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		r1.last = 1'b1;

		emit.count = accept ? n : 2'd0;
		emit.r0    = r0;
		emit.r1    = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= WORD_CLEAR;
		end else if (accept) begin
			word_q <= word_nxt;
		end
	end

endmodule

/* design/tcl_result_fifo.sv */
// Small result queue: takes up to two tokens a cycle, delivers one while the receiver is ready.
module tcl_result_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcl_pkg::emit_t              emit,
	output logic                        room,
	output logic [tcl_pkg::CNT_W-1:0]   count,
	tcl_out_if.source                   out_chan
);

	tcl_pkg::result_t mem_q [tcl_pkg::FIFO_DEPTH];
	logic [tcl_pkg::PTR_W-1:0] rd_q;
	logic [tcl_pkg::PTR_W-1:0] wr_q;
	logic [tcl_pkg::CNT_W-1:0] cnt_q;
	logic                      pop;
	tcl_pkg::result_t          head;

	assign head  = mem_q[rd_q];
	assign pop   = out_chan.valid && out_chan.ready;
	// Room for a worst-case pair of results
	assign room  = cnt_q <= tcl_pkg::CNT_W'(tcl_pkg::FIFO_DEPTH - 2);
	assign count = cnt_q;

	assign out_chan.valid            = cnt_q != '0;
	assign out_chan.token_kind       = head.kind;
	assign out_chan.token_length     = head.length;
	assign out_chan.token_char       = head.chr;
	assign out_chan.length_saturated = head.sat;
	assign out_chan.last_of_run      = head.last;

	always_ff @(posedge clk) begin
		if (emit.count != 2'd0) begin
			mem_q[wr_q] <= emit.r0;
		end
		if (emit.count == 2'd2) begin
			mem_q[wr_q + tcl_pkg::PTR_W'(1)] <= emit.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + tcl_pkg::PTR_W'(emit.count);
			rd_q  <= rd_q + tcl_pkg::PTR_W'(pop);
			cnt_q <= cnt_q + tcl_pkg::CNT_W'(emit.count) - tcl_pkg::CNT_W'(pop);
		end
	end

endmodule

/* design/token_classifier_lexer_top.sv */
// Token classifier top level: one source byte in, keyword/identifier/number/operator tokens out.
//
// char_chan carries one ASCII byte per item plus line_end, which flushes the word in
// progress after the byte is handled. token_chan carries one token per item with its
// kind, length, character (single-character tokens only), a saturation flag and
// last_of_run on the final token that an input byte caused. A byte yields zero, one
// or two tokens; whitespace and unknown bytes yield no token of their own.
// Tokens are registered in the result queue as their byte is accepted and leave it in order.
// Bytes are taken one per cycle while the queue has room for two tokens; the queue
// delivers one token per cycle while the receiver is ready, so two-token bytes fill it.
// The word state sits in registers that the classifier reads and updates in the
// same cycle, so back-to-back bytes need no bubble.
// When the receiver stalls, tokens wait in a four-entry queue; bytes are still taken
// while two or more free slots remain, then char_chan.ready drops until two are free again.
// Reset clears the word in progress (no word, length zero, all keyword candidates
// live) and empties the queue; nothing is offered until new bytes arrive.
// Words longer than MAX_WORD_LEN saturate; the flag marks them and they are never
// keywords. token_length carries the low eight bits of the saturated length.
module token_classifier_lexer_top #(
	parameter int MAX_WORD_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	tcl_in_if.sink     char_chan,
	tcl_out_if.source  token_chan
);

	tcl_pkg::emit_t            emit;
	logic                      room;
	logic                      accept;
	logic [tcl_pkg::CNT_W-1:0] q_count;

	// Take a byte only when both of its possible tokens fit
	assign char_chan.ready = room;
	assign accept          = char_chan.valid && room;

	tcl_word #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_word (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.char_in (char_chan.char_in),
		.line_end(char_chan.line_end),
		.emit    (emit)
	);

	tcl_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.room    (room),
		.count   (q_count),
		.out_chan(token_chan)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= tcl_pkg::CNT_W'(tcl_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		token_chan.valid && token_chan.token_kind >= tcl_pkg::TK_PUNCT |->
		token_chan.token_length == 8'd1 && !token_chan.length_saturated &&
		token_chan.token_char != 8'd0)
		else $error("single-character token malformed");

	a_word_char: assert property (@(posedge clk) disable iff (!arst_n)
		token_chan.valid && token_chan.token_kind < tcl_pkg::TK_PUNCT |->
		token_chan.token_char == 8'd0)
		else $error("word token carries a character");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		emit.count != 2'd0 |-> q_count <= tcl_pkg::CNT_W'(tcl_pkg::FIFO_DEPTH - 2))
		else $error("tokens produced without queue room");
`endif

endmodule
